// ===== hw/rtl/rrr_pkg.sv =====
// ---------------------------------------------------------------------------
// rrr_pkg: shared types, constants and helpers of the ray direction unit
// Fixed point formats, intermediate widths and the truncating product and saturation helpers.
// ---------------------------------------------------------------------------
package rrr_pkg;

  // Component format: signed Q3.20 in 24 bits.
  localparam int CompWidth = 24;
  localparam int FracBits  = 20;

  // Intermediate widths, worked out for the fixed component format.
  localparam int ProdW  = 28;  // one term of a dot product
  localparam int DotW   = 29;  // sum of three terms
  localparam int ScaleW = 30;  // 2(v.n) or the clamped cosine
  localparam int QW     = 34;  // scale times normal component
  localparam int WW     = 35;  // direction plus or minus that
  localparam int AW     = 40;  // perpendicular part, or the reflect result
  localparam int ClampW = 27;  // magnitude of a component before squaring
  localparam int SqW    = 34;  // one square, scaled
  localparam int SumW   = 36;  // sum of three squares
  localparam int RootW  = 21;  // square root and radicand, at most 1.0
  localparam int RemW   = 43;  // remainder of the root extraction
  localparam int FinW   = 25;  // root times normal component
  localparam int ResW   = 41;  // result before saturation

  // The root extraction settles two result bits per stage.
  localparam int SqrtStages = 11;

  typedef logic signed [CompWidth-1:0] comp_t;

  typedef enum logic {
    OP_REFLECT = 1'b0,
    OP_REFRACT = 1'b1
  } op_e;

  // Data that rides alongside the root extraction.
  typedef struct packed {
    logic                          flag;
    logic [2:0][CompWidth-1:0]     norm;
    logic [2:0][AW-1:0]            base;
  } side_t;

  // Shift a product right by the fraction bits, rounding toward zero.
  function automatic logic signed [63:0] trunc_q(logic signed [63:0] prod);
    logic signed [63:0] bias;
    bias = prod[63] ? 64'((64'd1 << FracBits) - 64'd1) : 64'sd0;
    return (prod + bias) >>> FracBits;
  endfunction

  // Clamp a wide result to the signed component range.
  function automatic comp_t sat_comp(logic signed [ResW-1:0] x);
    logic signed [ResW-1:0] hi;
    logic signed [ResW-1:0] lo;
    hi = ResW'((64'd1 << (CompWidth - 1)) - 64'd1);
    lo = -hi - ResW'(1);
    if (x > hi) begin
      return comp_t'(hi);
    end else if (x < lo) begin
      return comp_t'(lo);
    end
    return comp_t'(x);
  endfunction

endpackage

// ===== hw/rtl/rrr_if.sv =====
// ---------------------------------------------------------------------------
// rrr_if: item channels of the ray direction unit
// Valid/ready channels for the incoming rays and the resulting directions.
// ---------------------------------------------------------------------------
interface rrr_in_if;
  import rrr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 operation;
  comp_t                dir_x;
  comp_t                dir_y;
  comp_t                dir_z;
  comp_t                norm_x;
  comp_t                norm_y;
  comp_t                norm_z;
  logic [CompWidth-1:0] ratio;

  modport source (output valid, output operation, output dir_x, output dir_y,
                  output dir_z, output norm_x, output norm_y, output norm_z,
                  output ratio, input ready);
  modport sink   (input valid, input operation, input dir_x, input dir_y,
                  input dir_z, input norm_x, input norm_y, input norm_z,
                  input ratio, output ready);
endinterface

interface rrr_out_if;
  import rrr_pkg::*;

  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  logic  radicand_negative;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output radicand_negative, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input radicand_negative, output ready);
endinterface

// ===== hw/rtl/rrr_sqrt_pipe.sv =====
// ---------------------------------------------------------------------------
// rrr_sqrt_pipe: pipelined fixed point square root
// Digit-by-digit root of a Q.20 radicand, two result bits per stage.
// ---------------------------------------------------------------------------
module rrr_sqrt_pipe (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [rrr_pkg::RootW-1:0] rad_i,
  input  rrr_pkg::side_t           side_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [rrr_pkg::RootW-1:0] root_o,
  output rrr_pkg::side_t           side_o
);
  import rrr_pkg::*;

  logic [SqrtStages-1:0] vld_q;
  logic [SqrtStages-1:0] vin;
  logic [SqrtStages:0]   rdy;
  logic [RemW-1:0]       rem_q   [SqrtStages];
  logic [RemW-1:0]       rem_d   [SqrtStages];
  logic [RootW-1:0]      root_q  [SqrtStages];
  logic [RootW-1:0]      root_d  [SqrtStages];
  side_t                 side_q  [SqrtStages];
  side_t                 side_in [SqrtStages];

  // Handshake chain: a stage moves on when it is empty or its successor moves.
  always_comb begin
    rdy[SqrtStages] = ready_i;
    for (int s = SqrtStages - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
    vin[0]     = valid_i;
    side_in[0] = side_i;
    for (int s = 1; s < SqrtStages; s++) begin
      vin[s]     = vld_q[s-1];
      side_in[s] = side_q[s-1];
    end
  end

  // Two restoring root steps per stage, most significant bit first.
  always_comb begin
    logic [RemW-1:0]  rem;
    logic [RemW-1:0]  trial;
    logic [RootW-1:0] root;
    int               b;
    for (int s = 0; s < SqrtStages; s++) begin
      if (s == 0) begin
        rem  = RemW'(rad_i) << FracBits;
        root = '0;
      end else begin
        rem  = rem_q[s-1];
        root = root_q[s-1];
      end
      for (int j = 0; j < 2; j++) begin
        b = RootW - 1 - 2 * s - j;
        if (b >= 0) begin
          trial = (RemW'(root) << (b + 1)) + (RemW'(1) << (2 * b));
          if (rem >= trial) begin
            rem  = rem - trial;
            root = root | (RootW'(1) << b);
          end
        end
      end
      rem_d[s]  = rem;
      root_d[s] = root;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < SqrtStages; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vin[s];
        end
      end
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < SqrtStages; s++) begin
      if (rdy[s] && vin[s]) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1];
  assign side_o  = side_q[SqrtStages-1];

endmodule

// ===== hw/rtl/ray_reflect_refract_unit.sv =====
// ---------------------------------------------------------------------------
// ray_reflect_refract_unit: reflected or refracted ray direction
// Reflect gives v - 2(v.n)n; refract follows Snell's law in Q3.20.
// ---------------------------------------------------------------------------
// The unit is a twenty-stage pipeline that takes one item per clock cycle
// while its output is not stalled, and returns the results in order.
// Seven stages form the dot products, the cosine, the perpendicular part and
// the radicand; eleven stages extract the square root two bits at a time;
// two stages scale the normal and saturate. Every stage has its own valid bit
// and holds its item while the one after it cannot take it, so a stall at the output
// loses nothing and bubbles close up. A refract radicand below zero is taken
// as zero and radicand_negative is set; for reflect that flag is always zero.
module ray_reflect_refract_unit (
  input  logic clk_i,
  input  logic rst_ni,
  rrr_in_if.sink    in_i,
  rrr_out_if.source out_o
);
  import rrr_pkg::*;

  localparam logic signed [ScaleW-1:0] OneScale = ScaleW'(1) << FracBits;
  localparam logic [SumW-1:0]          OneSum   = SumW'(1) << FracBits;
  localparam logic [RootW-1:0]         OneRoot  = RootW'(1) << FracBits;
  localparam logic [AW-1:0]            ClampLim = AW'(1) << (ClampW - 1);

  // Handshake chain of the front stages (1 to 7).
  logic [8:1] rdy;
  logic [7:1] vin;
  logic [7:1] vld_q;
  logic       sq_ready;
  logic       sq_valid;
  logic       vld19_q;
  logic       vld20_q;
  logic       rdy19;
  logic       rdy20;

  always_comb begin
    rdy[8] = sq_ready;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vin[1] = in_i.valid;
    for (int k = 2; k <= 7; k++) begin
      vin[k] = vld_q[k-1];
    end
  end

  assign in_i.ready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= 7; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  // Stage 1: the three terms of v.n.
  logic                 op1_q;
  comp_t                v1_q [3];
  comp_t                n1_q [3];
  logic [CompWidth-1:0] ratio1_q;
  logic signed [ProdW-1:0] m1_q [3];
  comp_t                vin1 [3];
  comp_t                nin1 [3];

  assign vin1[0] = in_i.dir_x;
  assign vin1[1] = in_i.dir_y;
  assign vin1[2] = in_i.dir_z;
  assign nin1[0] = in_i.norm_x;
  assign nin1[1] = in_i.norm_y;
  assign nin1[2] = in_i.norm_z;

  always_ff @(posedge clk_i) begin
    logic signed [2*CompWidth-1:0] prod;
    if (rdy[1] && vin[1]) begin
      op1_q    <= in_i.operation;
      ratio1_q <= in_i.ratio;
      for (int i = 0; i < 3; i++) begin
        prod     = vin1[i] * nin1[i];
        v1_q[i]  <= vin1[i];
        n1_q[i]  <= nin1[i];
        m1_q[i]  <= ProdW'(trunc_q(64'(prod)));
      end
    end
  end

  // Stage 2: 2(v.n) for reflect, the clamped cosine for refract.
  logic                 op2_q;
  comp_t                v2_q [3];
  comp_t                n2_q [3];
  logic [CompWidth-1:0] ratio2_q;
  logic signed [ScaleW-1:0] k2_q;
  logic signed [DotW-1:0]   dot2;
  logic signed [ScaleW-1:0] cos2;

  always_comb begin
    dot2 = DotW'(m1_q[0]) + DotW'(m1_q[1]) + DotW'(m1_q[2]);
    cos2 = -ScaleW'(dot2);
    if (cos2 > OneScale) begin
      cos2 = OneScale;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vin[2]) begin
      op2_q    <= op1_q;
      ratio2_q <= ratio1_q;
      v2_q     <= v1_q;
      n2_q     <= n1_q;
      k2_q     <= (op_e'(op1_q) == OP_REFRACT) ? cos2 : (ScaleW'(dot2) <<< 1);
    end
  end

  // Stage 3: scale times each normal component.
  logic                 op3_q;
  comp_t                v3_q [3];
  comp_t                n3_q [3];
  logic [CompWidth-1:0] ratio3_q;
  logic signed [QW-1:0] q3_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [ScaleW+CompWidth-1:0] prod;
    if (rdy[3] && vin[3]) begin
      op3_q    <= op2_q;
      ratio3_q <= ratio2_q;
      v3_q     <= v2_q;
      n3_q     <= n2_q;
      for (int i = 0; i < 3; i++) begin
        prod    = k2_q * n2_q[i];
        q3_q[i] <= QW'(trunc_q(64'(prod)));
      end
    end
  end

  // Stage 4: v - 2(v.n)n for reflect, v + cos*n for refract.
  logic                 op4_q;
  comp_t                n4_q [3];
  logic [CompWidth-1:0] ratio4_q;
  logic signed [WW-1:0] w4_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[4] && vin[4]) begin
      op4_q    <= op3_q;
      ratio4_q <= ratio3_q;
      n4_q     <= n3_q;
      for (int i = 0; i < 3; i++) begin
        if (op_e'(op3_q) == OP_REFRACT) begin
          w4_q[i] <= WW'(v3_q[i]) + WW'(q3_q[i]);
        end else begin
          w4_q[i] <= WW'(v3_q[i]) - WW'(q3_q[i]);
        end
      end
    end
  end

  // Stage 5: perpendicular part ratio*w; reflect passes w through.
  logic                 op5_q;
  comp_t                n5_q [3];
  logic signed [AW-1:0] a5_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [WW+CompWidth:0] prod;
    if (rdy[5] && vin[5]) begin
      op5_q <= op4_q;
      n5_q  <= n4_q;
      for (int i = 0; i < 3; i++) begin
        prod = $signed({1'b0, ratio4_q}) * w4_q[i];
        if (op_e'(op4_q) == OP_REFRACT) begin
          a5_q[i] <= AW'(trunc_q(64'(prod)));
        end else begin
          a5_q[i] <= AW'(w4_q[i]);
        end
      end
    end
  end

  // Stage 6: squares of the perpendicular components. A magnitude past the
  // clamp already pushes the radicand below zero, so the clamp is exact.
  logic                 op6_q;
  comp_t                n6_q [3];
  logic signed [AW-1:0] a6_q [3];
  logic [SqW-1:0]       sq6_q [3];

  always_ff @(posedge clk_i) begin
    logic [AW-1:0]       mag;
    logic [ClampW-1:0]   cl;
    logic [2*ClampW-1:0] sq;
    if (rdy[6] && vin[6]) begin
      op6_q <= op5_q;
      n6_q  <= n5_q;
      a6_q  <= a5_q;
      for (int i = 0; i < 3; i++) begin
        mag = a5_q[i][AW-1] ? AW'(-a5_q[i]) : AW'(a5_q[i]);
        cl  = (mag >= ClampLim) ? ClampW'(ClampLim) : ClampW'(mag);
        sq  = cl * cl;
        sq6_q[i] <= sq[FracBits +: SqW];
      end
    end
  end

  // Stage 7: radicand 1 - |p|^2, clamped at zero; reflect takes a zero root.
  side_t            side7_q;
  logic [RootW-1:0] rad7_q;
  logic [SumW-1:0]  sum7;
  logic             neg7;

  always_comb begin
    sum7 = SumW'(sq6_q[0]) + SumW'(sq6_q[1]) + SumW'(sq6_q[2]);
    neg7 = (op_e'(op6_q) == OP_REFRACT) && (sum7 > OneSum);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7] && vin[7]) begin
      side7_q.flag <= neg7;
      for (int i = 0; i < 3; i++) begin
        side7_q.norm[i] <= n6_q[i];
        side7_q.base[i] <= a6_q[i];
      end
      if (op_e'(op6_q) == OP_REFRACT && !neg7) begin
        rad7_q <= OneRoot - RootW'(sum7);
      end else begin
        rad7_q <= '0;
      end
    end
  end

  // Stages 8 to 18: square root.
  logic [RootW-1:0] root18;
  side_t            side18;

  rrr_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[7]),
    .ready_o (sq_ready),
    .rad_i   (rad7_q),
    .side_i  (side7_q),
    .valid_o (sq_valid),
    .ready_i (rdy19),
    .root_o  (root18),
    .side_o  (side18)
  );

  // Back stages handshake.
  assign rdy20 = !vld20_q || out_o.ready;
  assign rdy19 = !vld19_q || rdy20;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld19_q <= 1'b0;
      vld20_q <= 1'b0;
    end else begin
      if (rdy19) begin
        vld19_q <= sq_valid;
      end
      if (rdy20) begin
        vld20_q <= vld19_q;
      end
    end
  end

  // Stage 19: root times each normal component.
  logic                   flag19_q;
  logic signed [AW-1:0]   a19_q [3];
  logic signed [FinW-1:0] f19_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [RootW+CompWidth:0] prod;
    if (rdy19 && sq_valid) begin
      flag19_q <= side18.flag;
      for (int i = 0; i < 3; i++) begin
        prod     = $signed({1'b0, root18}) * $signed(side18.norm[i]);
        a19_q[i] <= $signed(side18.base[i]);
        f19_q[i] <= FinW'(trunc_q(64'(prod)));
      end
    end
  end

  // Stage 20: subtract and saturate into the output register.
  comp_t res20_q [3];
  logic  flag20_q;

  always_ff @(posedge clk_i) begin
    if (rdy20 && vld19_q) begin
      flag20_q <= flag19_q;
      for (int i = 0; i < 3; i++) begin
        res20_q[i] <= sat_comp(ResW'(a19_q[i]) - ResW'(f19_q[i]));
      end
    end
  end

  assign out_o.valid             = vld20_q;
  assign out_o.out_x             = res20_q[0];
  assign out_o.out_y             = res20_q[1];
  assign out_o.out_z             = res20_q[2];
  assign out_o.radicand_negative = flag20_q;

endmodule

// ===== hw/rtl/rrr_checker.sv =====
// ---------------------------------------------------------------------------
// rrr_checker: port level checks of the ray direction unit
// Counts items in flight and checks ordering of the handshakes.
// ---------------------------------------------------------------------------
module rrr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input rrr_pkg::comp_t      out_x_i,
  input logic                out_flag_i
);
  import rrr_pkg::*;

  localparam int Depth = 7 + SqrtStages + 2;

  logic [5:0] inflight_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Items taken but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 6'(in_acc) - 6'(out_acc);
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i)
      && $stable(out_flag_i))
    else $error("result changed while stalled");

  // No result without an item in flight.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 6'd0)
    else $error("result without a pending item");

  // The pipeline never holds more items than it has stages.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 6'(Depth))
    else $error("more items in flight than stages");

  // With the output ready, the whole pipeline moves and the input is ready.
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output accepts");

endmodule

bind ray_reflect_refract_unit rrr_checker u_rrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.out_x),
  .out_flag_i  (out_o.radicand_negative)
);
